// ===== rtl/core/otsu_threshold_binarizer_macros.svh =====
// Assertion macros for the Otsu binarizer core.
// Used by files that check their own logic; expects clk and rst_n in scope.
`ifndef OTSU_THRESHOLD_BINARIZER_MACROS_SVH
`define OTSU_THRESHOLD_BINARIZER_MACROS_SVH

// condition must hold in the same cycle
`define OTB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("otb: same-cycle check failed");

// condition must hold in the next cycle
`define OTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("otb: next-cycle check failed");

`endif

// ===== rtl/core/otb_pkg.sv =====
// Shared constants, datapath command codes and control structs for the Otsu binarizer.
// No dependencies.
package otb_pkg;

  localparam int LEVELS = 256;
  localparam int AW     = $clog2(LEVELS);
  localparam int CB     = 24;            // histogram bin width
  localparam int NB     = CB + AW;       // pixel count total
  localparam int SB     = CB + 2 * AW;   // intensity sum total
  localparam int PB     = SB + NB;       // S*w0 and s0*N
  localparam int NUMB   = 2 * PB;        // squared difference
  localparam int DENB   = 2 * NB;        // w0*(N-w0)
  localparam int LHSB   = NUMB + DENB;   // cross products
  localparam int MA     = NUMB;          // multiplicand width
  localparam int MB     = PB;            // multiplier width, covers DENB too
  localparam int MP     = MA + MB;
  localparam int MCW    = $clog2(MB + 1);

  localparam logic [CB-1:0] CMAX     = {CB{1'b1}};
  localparam logic [AW-1:0] LAST_BIN = AW'(LEVELS - 1);
  localparam logic [AW-1:0] LAST_K   = AW'(LEVELS - 2);

  // luma: floor(x/1000) = (x * ceil(2^28/1000)) >> 28 for x < 493447
  localparam int WSB    = 18;
  localparam int LUM_SH = 28;
  localparam logic [18:0] LUM_M = 19'd268436;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WSUM,
    OP_LUM,
    OP_BIN_RD,
    OP_BIN_WR,
    OP_SRCH_INIT,
    OP_TOT_RD,
    OP_TOT_ACC,
    OP_CUM_RD,
    OP_CUM_ACC,
    OP_MUL_P,
    OP_MUL_Q,
    OP_MUL_NUM,
    OP_MUL_DEN,
    OP_MUL_LHS,
    OP_MUL_RHS,
    OP_CMP,
    OP_OUT_PIX,
    OP_OUT_THR
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [AW-1:0]   addr;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic last;
    logic skip;
    logic mul_done;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/core/otb_ifs.sv =====
// Valid/ready channel interfaces: pixel input, result output, config write.
// Depends on nothing.
interface otb_pix_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;
  modport source(output valid, mode, red, green, blue, last_pixel, input ready);
  modport sink(input valid, mode, red, green, blue, last_pixel, output ready);
endinterface

interface otb_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] value;
  logic       count_overflow;
  modport source(output valid, result_kind, value, count_overflow, input ready);
  modport sink(input valid, result_kind, value, count_overflow, output ready);
endinterface

interface otb_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/core/otb_mul.sv =====
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
// Depends on otb_pkg.
module otb_mul (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [otb_pkg::MA-1:0] a,
  input  logic [otb_pkg::MB-1:0] b,
  output logic                   busy,
  output logic                   done,
  output logic [otb_pkg::MP-1:0] prod
);

  logic [otb_pkg::MA:0]    hi_r, sum;
  logic [otb_pkg::MB-1:0]  lo_r;
  logic [otb_pkg::MA-1:0]  a_r;
  logic [otb_pkg::MCW-1:0] cnt_r;
  logic                    busy_r, done_r;

  always_comb begin
    sum = hi_r + (lo_r[0] ? {1'b0, a_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= otb_pkg::MCW'(otb_pkg::MB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == otb_pkg::MCW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r <= '0;
      lo_r <= b;
      a_r  <= a;
    end else if (busy_r) begin
      hi_r <= {1'b0, sum[otb_pkg::MA:1]};
      lo_r <= {sum[0], lo_r[otb_pkg::MB-1:1]};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = {hi_r[otb_pkg::MA-1:0], lo_r};

endmodule

// ===== rtl/core/otb_datapath.sv =====
// Datapath: pixel registers, histogram memory, search accumulators, result register.
// Depends on otb_pkg, otb_ifs, otb_mul and the macros header.
`include "otsu_threshold_binarizer_macros.svh"

module otb_datapath (
  input  logic                clk,
  input  logic                rst_n,
  otb_pix_if.sink             in_pix,
  otb_res_if.source           out_res,
  otb_cfg_if.sink             cfg_wr,
  input  logic                in_ready,
  input  otb_pkg::dp_cmd_t    cmd,
  output otb_pkg::dp_sts_t    sts
);

  localparam int CB = otb_pkg::CB;
  localparam int AW = otb_pkg::AW;

  // pixel
  logic                    gray_r, mode_r, last_r;
  logic [7:0]              red_r, green_r, blue_r, inten_r;
  logic [otb_pkg::WSB-1:0] wsum_r, wsum_nxt;
  logic [36:0]             lum_prod;

  // histogram
  logic [CB-1:0]           mem [otb_pkg::LEVELS];
  logic [otb_pkg::LEVELS-1:0] vld_r;
  logic [CB-1:0]           rdd_r, bin;
  logic                    rdv_r;
  logic [AW-1:0]           ra;
  logic                    we;

  // search
  logic [otb_pkg::NB-1:0]   n_r, w0_r;
  logic [otb_pkg::SB-1:0]   s_r, s0_r;
  logic [CB+AW-1:0]         wprod;
  logic [otb_pkg::PB-1:0]   p_r, q_r, d;
  logic [otb_pkg::NUMB-1:0] num_r, bnum_r;
  logic [otb_pkg::DENB-1:0] den_r, bden_r;
  logic [otb_pkg::LHSB-1:0] lhs_r, rhs_r;
  logic [7:0]               bthr_r, thr_r;
  logic                     ovf_r;

  // multiplier
  logic                   mul_start, mul_busy, mul_done;
  logic [otb_pkg::MA-1:0] mul_a;
  logic [otb_pkg::MB-1:0] mul_b;
  logic [otb_pkg::MP-1:0] mul_p;
  otb_pkg::dp_op_t        mdst_r;

  // result
  logic       out_valid_r, out_kind_r, out_ovf_r, out_load;
  logic [7:0] out_val_r;

  assign in_pix.ready = in_ready;
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    wsum_nxt = otb_pkg::WSB'(red_r) * otb_pkg::WSB'(299)
             + otb_pkg::WSB'(green_r) * otb_pkg::WSB'(587)
             + otb_pkg::WSB'(blue_r) * otb_pkg::WSB'(114);
    lum_prod = {19'd0, wsum_r} * {18'd0, otb_pkg::LUM_M};
    bin      = rdv_r ? rdd_r : '0;
    wprod    = {{AW{1'b0}}, bin} * {{CB{1'b0}}, cmd.addr};
    d        = (p_r >= q_r) ? (p_r - q_r) : (q_r - p_r);
    ra       = (cmd.op == otb_pkg::OP_BIN_RD) ? inten_r : cmd.addr;
    we       = (cmd.op == otb_pkg::OP_BIN_WR) && (bin != otb_pkg::CMAX);
    out_load = (cmd.op == otb_pkg::OP_OUT_PIX) || (cmd.op == otb_pkg::OP_OUT_THR);
  end

  always_comb begin
    mul_start = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    case (cmd.op)
      otb_pkg::OP_MUL_P: begin
        mul_a = otb_pkg::MA'(s_r);
        mul_b = otb_pkg::MB'(w0_r);
      end
      otb_pkg::OP_MUL_Q: begin
        mul_a = otb_pkg::MA'(s0_r);
        mul_b = otb_pkg::MB'(n_r);
      end
      otb_pkg::OP_MUL_NUM: begin
        mul_a = otb_pkg::MA'(d);
        mul_b = d;
      end
      otb_pkg::OP_MUL_DEN: begin
        mul_a = otb_pkg::MA'(w0_r);
        mul_b = otb_pkg::MB'(n_r - w0_r);
      end
      otb_pkg::OP_MUL_LHS: begin
        mul_a = num_r;
        mul_b = otb_pkg::MB'(bden_r);
      end
      otb_pkg::OP_MUL_RHS: begin
        mul_a = bnum_r;
        mul_b = otb_pkg::MB'(den_r);
      end
      default: mul_start = 1'b0;
    endcase
  end

  otb_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // histogram array, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[inten_r] <= bin + 1'b1;
    end
    rdd_r <= mem[ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_r      <= 1'b0;
      vld_r       <= '0;
      rdv_r       <= 1'b0;
      thr_r       <= 8'd1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        gray_r <= cfg_wr.data;
      end
      rdv_r <= vld_r[ra];
      if (we) begin
        vld_r[inten_r] <= 1'b1;
      end
      if ((cmd.op == otb_pkg::OP_BIN_WR) && (bin == otb_pkg::CMAX)) begin
        ovf_r <= 1'b1;
      end
      if (out_res.valid && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end
      if (cmd.op == otb_pkg::OP_OUT_THR) begin
        thr_r <= bthr_r;
        ovf_r <= 1'b0;
        vld_r <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      otb_pkg::OP_LOAD: begin
        mode_r  <= in_pix.mode;
        last_r  <= in_pix.last_pixel;
        red_r   <= in_pix.red;
        green_r <= in_pix.green;
        blue_r  <= in_pix.blue;
      end
      otb_pkg::OP_WSUM: wsum_r <= wsum_nxt;
      otb_pkg::OP_LUM: begin
        inten_r <= gray_r ? red_r : lum_prod[otb_pkg::LUM_SH+7:otb_pkg::LUM_SH];
      end
      otb_pkg::OP_SRCH_INIT: begin
        n_r    <= '0;
        s_r    <= '0;
        w0_r   <= '0;
        s0_r   <= '0;
        bnum_r <= '0;
        bden_r <= otb_pkg::DENB'(1);
        bthr_r <= 8'd1;
      end
      otb_pkg::OP_TOT_ACC: begin
        n_r <= n_r + otb_pkg::NB'(bin);
        s_r <= s_r + otb_pkg::SB'(wprod);
      end
      otb_pkg::OP_CUM_ACC: begin
        w0_r <= w0_r + otb_pkg::NB'(bin);
        s0_r <= s0_r + otb_pkg::SB'(wprod);
      end
      otb_pkg::OP_CMP: begin
        if (lhs_r > rhs_r) begin
          bnum_r <= num_r;
          bden_r <= den_r;
          bthr_r <= cmd.addr + 8'd1;
        end
      end
      otb_pkg::OP_OUT_PIX: begin
        out_kind_r <= 1'b1;
        out_val_r  <= (inten_r < thr_r) ? 8'd0 : 8'd255;
        out_ovf_r  <= 1'b0;
      end
      otb_pkg::OP_OUT_THR: begin
        out_kind_r <= 1'b0;
        out_val_r  <= bthr_r;
        out_ovf_r  <= ovf_r;
      end
      default: ;
    endcase
    if (mul_start) begin
      mdst_r <= cmd.op;
    end
    if (mul_done) begin
      case (mdst_r)
        otb_pkg::OP_MUL_P:   p_r   <= mul_p[otb_pkg::PB-1:0];
        otb_pkg::OP_MUL_Q:   q_r   <= mul_p[otb_pkg::PB-1:0];
        otb_pkg::OP_MUL_NUM: num_r <= mul_p[otb_pkg::NUMB-1:0];
        otb_pkg::OP_MUL_DEN: den_r <= mul_p[otb_pkg::DENB-1:0];
        otb_pkg::OP_MUL_LHS: lhs_r <= mul_p[otb_pkg::LHSB-1:0];
        otb_pkg::OP_MUL_RHS: rhs_r <= mul_p[otb_pkg::LHSB-1:0];
        default: ;
      endcase
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.result_kind    = out_kind_r;
  assign out_res.value          = out_val_r;
  assign out_res.count_overflow = out_ovf_r;

  always_comb begin
    sts.mode     = mode_r;
    sts.last     = last_r;
    sts.skip     = (w0_r == '0) || (w0_r == n_r);
    sts.mul_done = mul_done;
    sts.out_busy = out_valid_r && !out_res.ready;
  end

  `OTB_ASSERT_NOW(a_mul_not_busy, mul_start, !mul_busy)
  `OTB_ASSERT_NOW(a_no_overwrite, out_load, !out_valid_r || out_res.ready)
  `OTB_ASSERT_NEXT(a_hist_cleared, cmd.op == otb_pkg::OP_OUT_THR, vld_r == '0)

endmodule

// ===== rtl/core/otb_ctrl.sv =====
// Sequencer for pixel handling and the threshold search.
// Depends on otb_pkg.
module otb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  otb_pkg::dp_sts_t sts,
  output logic             in_ready,
  output otb_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_WSUM, S_LUM, S_PIX, S_BRD, S_BWR, S_INIT, S_TRD, S_TACC,
    S_CRD, S_CACC, S_CHK, S_MUL, S_MWAIT, S_CMP, S_FIN
  } state_t;

  state_t                   state_r, state_nxt;
  logic [otb_pkg::AW-1:0]   k_r, k_nxt;
  otb_pkg::dp_op_t          mop_r, mop_nxt, mop_next;

  always_comb begin
    case (mop_r)
      otb_pkg::OP_MUL_P:   mop_next = otb_pkg::OP_MUL_Q;
      otb_pkg::OP_MUL_Q:   mop_next = otb_pkg::OP_MUL_NUM;
      otb_pkg::OP_MUL_NUM: mop_next = otb_pkg::OP_MUL_DEN;
      otb_pkg::OP_MUL_DEN: mop_next = otb_pkg::OP_MUL_LHS;
      otb_pkg::OP_MUL_LHS: mop_next = otb_pkg::OP_MUL_RHS;
      default:             mop_next = otb_pkg::OP_MUL_P;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    mop_nxt   = mop_r;
    in_ready  = 1'b0;
    cmd.op    = otb_pkg::OP_NONE;
    cmd.addr  = k_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = otb_pkg::OP_LOAD;
          state_nxt = S_WSUM;
        end
      end
      S_WSUM: begin
        cmd.op    = otb_pkg::OP_WSUM;
        state_nxt = S_LUM;
      end
      S_LUM: begin
        cmd.op    = otb_pkg::OP_LUM;
        state_nxt = sts.mode ? S_PIX : S_BRD;
      end
      S_PIX: begin
        if (!sts.out_busy) begin
          cmd.op    = otb_pkg::OP_OUT_PIX;
          state_nxt = S_IDLE;
        end
      end
      S_BRD: begin
        cmd.op    = otb_pkg::OP_BIN_RD;
        state_nxt = S_BWR;
      end
      S_BWR: begin
        cmd.op    = otb_pkg::OP_BIN_WR;
        state_nxt = sts.last ? S_INIT : S_IDLE;
      end
      S_INIT: begin
        cmd.op    = otb_pkg::OP_SRCH_INIT;
        k_nxt     = '0;
        state_nxt = S_TRD;
      end
      S_TRD: begin
        cmd.op    = otb_pkg::OP_TOT_RD;
        state_nxt = S_TACC;
      end
      S_TACC: begin
        cmd.op = otb_pkg::OP_TOT_ACC;
        if (k_r == otb_pkg::LAST_BIN) begin
          k_nxt     = '0;
          state_nxt = S_CRD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_TRD;
        end
      end
      S_CRD: begin
        cmd.op    = otb_pkg::OP_CUM_RD;
        state_nxt = S_CACC;
      end
      S_CACC: begin
        cmd.op    = otb_pkg::OP_CUM_ACC;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.skip) begin
          if (k_r == otb_pkg::LAST_K) begin
            state_nxt = S_FIN;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_CRD;
          end
        end else begin
          mop_nxt   = otb_pkg::OP_MUL_P;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = mop_r;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.mul_done) begin
          if (mop_r == otb_pkg::OP_MUL_RHS) begin
            state_nxt = S_CMP;
          end else begin
            mop_nxt   = mop_next;
            state_nxt = S_MUL;
          end
        end
      end
      S_CMP: begin
        cmd.op = otb_pkg::OP_CMP;
        if (k_r == otb_pkg::LAST_K) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_CRD;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.op    = otb_pkg::OP_OUT_THR;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      mop_r   <= otb_pkg::OP_MUL_P;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      mop_r   <= mop_nxt;
    end
  end

endmodule

// ===== rtl/core/otsu_threshold_binarizer.sv =====
// Otsu threshold binarizer top level: sequencer plus datapath.
// Binarize pixel: load, weighted sum, luma, result register. Histogram pixel: load, weighted
// sum, luma, bin read, bin write, one at a time. Frame end: a total pass over all bins, then
// per k a cumulative read, accumulate and skip check; an unskipped k adds 6 shift-add products
// and a compare; the products run on the 72-bit serial multiplier.
// Reset (sync, rst_n low): histogram empty via valid bits, threshold 1, overflow 0, gray off.
// Depends on otb_pkg, otb_ifs, otb_ctrl, otb_datapath.
module otsu_threshold_binarizer (
  input  logic      clk,
  input  logic      rst_n,
  otb_pix_if.sink   in_pix,
  otb_res_if.source out_res,
  otb_cfg_if.sink   cfg_wr
);

  // command/status link between sequencer and datapath
  otb_pkg::dp_cmd_t cmd;
  otb_pkg::dp_sts_t sts;
  logic             in_ready;

  // sequencer: one pixel in flight; pixel transfer only in idle
  otb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pix.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // datapath: histogram, search arithmetic, result register
  otb_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .out_res  (out_res),
    .cfg_wr   (cfg_wr),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
